// File: rtl/ift_pkg.sv
// ----------------------------------------------------------------------------
// ift_pkg
// Shared request types and protocol constants for the IPv4 flow tuple
// extractor.
// ----------------------------------------------------------------------------
package ift_pkg;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_VLAN = 16'h8100;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [3:0] IP_VERSION_4 = 4'd4;
    localparam logic [6:0] OFFSET_MAX   = 7'd127;
    localparam logic [6:0] OFF_TYPE_HI  = 7'd12;
    localparam logic [6:0] OFF_TYPE_LO  = 7'd13;
    localparam logic [6:0] OFF_INNER_HI = 7'd16;
    localparam logic [6:0] OFF_INNER_LO = 7'd17;
    localparam logic [6:0] IP_START     = 7'd14;
    localparam logic [6:0] IP_START_TAG = 7'd18;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FILTERED    = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_SHORT       = 2'd3;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        last_byte;
        logic        is_receive;
        logic [15:0] interface_index;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  protocol_number;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } t_out_req;

endpackage

// File: rtl/ipv4_flow_tuple_extractor.sv
// ----------------------------------------------------------------------------
// ipv4_flow_tuple_extractor
// Parses an Ethernet frame byte by byte and reports the IPv4 five-tuple.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle unless a last byte waits on a stalled
// result; set by the per-byte offset compare and capture in the parser.
// A last byte is taken into the input register, and its result is then loaded
// into the result register; a stalled result holds the last byte.
// Reset clears the interface filter, the parse state and both stage valids.
// ----------------------------------------------------------------------------
module ipv4_flow_tuple_extractor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  logic              i_in_valid,
    input  ift_pkg::t_in_req  i_in_req,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output ift_pkg::t_out_req o_out_req,
    input  logic              i_out_stall
);

    logic [15:0]       r_interface_filter;
    logic              w_in_valid;
    ift_pkg::t_in_req  w_in_req;
    logic              w_out_free;
    logic              w_advance;
    logic              w_load;
    ift_pkg::t_out_req w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interface_filter <= '0;
        end else if (i_cfg_wr_en) begin
            r_interface_filter <= i_cfg_wr_data;
        end
    end

    assign w_advance = w_in_valid && (!w_in_req.last_byte || w_out_free);
    assign w_load    = w_advance && w_in_req.last_byte;

    ift_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .o_in_stall (o_in_stall),
        .i_advance  (w_advance),
        .o_valid    (w_in_valid),
        .o_req      (w_in_req)
    );

    ift_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_advance          (w_advance),
        .i_req              (w_in_req),
        .i_interface_filter (r_interface_filter),
        .o_result           (w_result)
    );

    ift_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_result    (w_result),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall)
    );

    a_rise_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_load))
        else $error("result appeared without a last byte");

    a_bad_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.status != ift_pkg::ST_OK) |->
        (o_out_req.source_address == 32'd0 && o_out_req.dest_address == 32'd0 &&
         o_out_req.protocol_number == 8'd0 && o_out_req.source_port == 16'd0 &&
         o_out_req.dest_port == 16'd0))
        else $error("rejected result carries tuple data");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && o_out_valid) |-> !i_out_stall)
        else $error("result register overwritten while stalled");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_in_valid && w_in_req.last_byte))
        else $error("input stalled without a pending last byte");

endmodule

// File: rtl/ift_in_reg.sv
// ----------------------------------------------------------------------------
// ift_in_reg
// Input register stage that holds one byte request until the parser takes it.
// ----------------------------------------------------------------------------
module ift_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ift_pkg::t_in_req i_in_req,
    output logic             o_in_stall,
    input  logic             i_advance,
    output logic             o_valid,
    output ift_pkg::t_in_req o_req
);

    logic             r_valid;
    logic             n_valid;
    ift_pkg::t_in_req r_req;
    logic             w_accept;

    assign o_in_stall = r_valid && !i_advance;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign n_valid    = w_accept || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// File: rtl/ift_parser.sv
// ----------------------------------------------------------------------------
// ift_parser
// Per-byte header capture and end-of-frame classification of the tuple.
// ----------------------------------------------------------------------------
module ift_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  ift_pkg::t_in_req  i_req,
    input  logic [15:0]       i_interface_filter,
    output ift_pkg::t_out_req o_result
);

    logic [6:0]  r_offset;
    logic [15:0] r_outer;
    logic [15:0] r_inner;
    logic [7:0]  r_hvl;
    logic [7:0]  r_proto;
    logic [31:0] r_src;
    logic [31:0] r_dst;
    logic [15:0] r_sport;
    logic [15:0] r_dport;

    logic [6:0]  n_offset;
    logic [15:0] n_outer;
    logic [15:0] n_inner;
    logic [7:0]  n_hvl;
    logic [7:0]  n_proto;
    logic [31:0] n_src;
    logic [31:0] n_dst;
    logic [15:0] n_sport;
    logic [15:0] n_dport;

    logic [7:0]  w_byte;
    logic [6:0]  w_ip_start;
    logic        w_in_ip;
    logic [6:0]  w_rel;
    logic [7:0]  w_hvl_eff;
    logic [6:0]  w_pbase;
    logic [7:0]  w_count;
    logic [1:0]  w_status;

    function automatic logic [1:0] judge(
        input logic [7:0]  n,
        input logic [15:0] ifidx,
        input logic [15:0] filter,
        input logic [15:0] outer,
        input logic [15:0] inner,
        input logic [7:0]  hvl,
        input logic [7:0]  proto
    );
        logic [7:0] ipst;
        if (filter != 16'd0 && ifidx != filter) begin
            return ift_pkg::ST_FILTERED;
        end
        if (n < {1'b0, ift_pkg::IP_START}) begin
            return ift_pkg::ST_SHORT;
        end
        if (outer == ift_pkg::ETYPE_VLAN) begin
            if (n < {1'b0, ift_pkg::IP_START_TAG}) begin
                return ift_pkg::ST_SHORT;
            end
            if (inner != ift_pkg::ETYPE_IPV4) begin
                return ift_pkg::ST_UNSUPPORTED;
            end
            ipst = {1'b0, ift_pkg::IP_START_TAG};
        end else if (outer != ift_pkg::ETYPE_IPV4) begin
            return ift_pkg::ST_UNSUPPORTED;
        end else begin
            ipst = {1'b0, ift_pkg::IP_START};
        end
        if (n < ipst + 8'd1) begin
            return ift_pkg::ST_SHORT;
        end
        if (hvl[7:4] != ift_pkg::IP_VERSION_4) begin
            return ift_pkg::ST_UNSUPPORTED;
        end
        if (n < ipst + 8'd10) begin
            return ift_pkg::ST_SHORT;
        end
        if (proto != ift_pkg::PROTO_TCP && proto != ift_pkg::PROTO_UDP &&
            proto != ift_pkg::PROTO_ICMP) begin
            return ift_pkg::ST_UNSUPPORTED;
        end
        if (n < ipst + 8'd20) begin
            return ift_pkg::ST_SHORT;
        end
        if (proto != ift_pkg::PROTO_ICMP &&
            n < ipst + {2'b00, hvl[3:0], 2'b00} + 8'd4) begin
            return ift_pkg::ST_SHORT;
        end
        return ift_pkg::ST_OK;
    endfunction

    assign w_byte     = i_req.frame_byte;
    assign w_ip_start = (r_outer == ift_pkg::ETYPE_VLAN) ? ift_pkg::IP_START_TAG
                                                         : ift_pkg::IP_START;
    assign w_in_ip    = (r_offset >= ift_pkg::IP_START) && (r_offset >= w_ip_start);
    assign w_rel      = r_offset - w_ip_start;
    assign w_hvl_eff  = (w_rel == 7'd0) ? w_byte : r_hvl;
    assign w_pbase    = {1'b0, w_hvl_eff[3:0], 2'b00};
    assign w_count    = {1'b0, r_offset} + 8'd1;

    always_comb begin
        n_offset = (r_offset < ift_pkg::OFFSET_MAX) ? r_offset + 7'd1 : r_offset;
        n_outer  = r_outer;
        n_inner  = r_inner;
        n_hvl    = r_hvl;
        n_proto  = r_proto;
        n_src    = r_src;
        n_dst    = r_dst;
        n_sport  = r_sport;
        n_dport  = r_dport;
        if (r_offset == ift_pkg::OFF_TYPE_HI || r_offset == ift_pkg::OFF_TYPE_LO) begin
            n_outer = {r_outer[7:0], w_byte};
        end
        if (r_outer == ift_pkg::ETYPE_VLAN &&
            (r_offset == ift_pkg::OFF_INNER_HI || r_offset == ift_pkg::OFF_INNER_LO)) begin
            n_inner = {r_inner[7:0], w_byte};
        end
        if (w_in_ip) begin
            if (w_rel == 7'd0) begin
                n_hvl = w_byte;
            end
            if (w_rel == 7'd9) begin
                n_proto = w_byte;
            end
            if (w_rel >= 7'd12 && w_rel <= 7'd15) begin
                n_src = {r_src[23:0], w_byte};
            end
            if (w_rel >= 7'd16 && w_rel <= 7'd19) begin
                n_dst = {r_dst[23:0], w_byte};
            end
            if (w_rel == w_pbase || w_rel == w_pbase + 7'd1) begin
                n_sport = {r_sport[7:0], w_byte};
            end
            if (w_rel == w_pbase + 7'd2 || w_rel == w_pbase + 7'd3) begin
                n_dport = {r_dport[7:0], w_byte};
            end
        end
    end

    assign w_status = judge(w_count, i_req.interface_index, i_interface_filter,
                            n_outer, n_inner, n_hvl, n_proto);

    always_comb begin
        o_result = '0;
        o_result.status = w_status;
        if (w_status == ift_pkg::ST_OK) begin
            o_result.protocol_number = n_proto;
            if (i_req.is_receive) begin
                o_result.source_address = n_dst;
                o_result.dest_address   = n_src;
            end else begin
                o_result.source_address = n_src;
                o_result.dest_address   = n_dst;
            end
            if (n_proto != ift_pkg::PROTO_ICMP) begin
                o_result.source_port = i_req.is_receive ? n_dport : n_sport;
                o_result.dest_port   = i_req.is_receive ? n_sport : n_dport;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_req.last_byte)) begin
            r_offset <= '0;
            r_outer  <= '0;
            r_inner  <= '0;
            r_hvl    <= '0;
            r_proto  <= '0;
            r_src    <= '0;
            r_dst    <= '0;
            r_sport  <= '0;
            r_dport  <= '0;
        end else if (i_advance) begin
            r_offset <= n_offset;
            r_outer  <= n_outer;
            r_inner  <= n_inner;
            r_hvl    <= n_hvl;
            r_proto  <= n_proto;
            r_src    <= n_src;
            r_dst    <= n_dst;
            r_sport  <= n_sport;
            r_dport  <= n_dport;
        end
    end

endmodule

// File: rtl/ift_out_reg.sv
// ----------------------------------------------------------------------------
// ift_out_reg
// Result register that holds one tuple request until the receiver takes it.
// ----------------------------------------------------------------------------
module ift_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ift_pkg::t_out_req i_result,
    output logic              o_free,
    output logic              o_out_valid,
    output ift_pkg::t_out_req o_out_req,
    input  logic              i_out_stall
);

    logic              r_valid;
    logic              n_valid;
    ift_pkg::t_out_req r_req;

    assign o_free  = !r_valid || !i_out_stall;
    assign n_valid = i_load || (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_req <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_req   = r_req;

endmodule

// File: dv/ipv4_flow_tuple_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_flow_tuple_extractor_tb
// Streams Ethernet frames byte by byte into the tuple extractor and checks
// every result. A local parser model predicts the status and tuple of each
// frame. Directed frames come first: extremes, all statuses, VLAN tags,
// small IHL and long frames. Random frames follow under several interface
// filter settings. Both handshakes idle at random, and the receiver holds
// off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module ipv4_flow_tuple_extractor_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 400;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [15:0]       cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    ift_pkg::t_in_req  in_req = '0;
    logic              in_stall;
    logic              out_valid;
    ift_pkg::t_out_req out_req;
    logic              out_stall = 1'b0;

    ift_pkg::t_in_req  frame_reqs[$];
    ift_pkg::t_out_req tuple_q[$];

    logic [15:0] filter_q = '0;
    logic [6:0]  off_q = '0;
    logic [15:0] outer_q = '0;
    logic [15:0] inner_q = '0;
    logic [7:0]  hvl_q = '0;
    logic [7:0]  proto_q = '0;
    logic [31:0] sa_q = '0;
    logic [31:0] da_q = '0;
    logic [15:0] sp_q = '0;
    logic [15:0] dp_q = '0;

    bit in_taken = 1'b0;
    int err_cnt = 0;
    int n_bytes = 0;
    int n_tuples = 0;
    int n_settings = 0;
    int status_cnt[4] = '{0, 0, 0, 0};
    bit hold_done = 1'b0;

    ipv4_flow_tuple_extractor DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_req      (in_req),
        .o_in_stall    (in_stall),
        .o_out_valid   (out_valid),
        .o_out_req     (out_req),
        .i_out_stall   (out_stall)
    );

    always #5 clk = ~clk;

    function automatic logic [1:0] frame_status(int n, logic [15:0] ifx);
        int ip_start;
        if (filter_q != 0 && ifx != filter_q) return ift_pkg::ST_FILTERED;
        if (n < int'(ift_pkg::IP_START)) return ift_pkg::ST_SHORT;
        if (outer_q == ift_pkg::ETYPE_VLAN) begin
            if (n < int'(ift_pkg::IP_START_TAG)) return ift_pkg::ST_SHORT;
            if (inner_q != ift_pkg::ETYPE_IPV4) return ift_pkg::ST_UNSUPPORTED;
            ip_start = int'(ift_pkg::IP_START_TAG);
        end else if (outer_q != ift_pkg::ETYPE_IPV4) begin
            return ift_pkg::ST_UNSUPPORTED;
        end else begin
            ip_start = int'(ift_pkg::IP_START);
        end
        if (n < ip_start + 1) return ift_pkg::ST_SHORT;
        if (hvl_q[7:4] != ift_pkg::IP_VERSION_4) return ift_pkg::ST_UNSUPPORTED;
        if (n < ip_start + 10) return ift_pkg::ST_SHORT;
        if (proto_q != ift_pkg::PROTO_TCP && proto_q != ift_pkg::PROTO_UDP &&
            proto_q != ift_pkg::PROTO_ICMP)
            return ift_pkg::ST_UNSUPPORTED;
        if (n < ip_start + 20) return ift_pkg::ST_SHORT;
        if (proto_q != ift_pkg::PROTO_ICMP && n < ip_start + 4 * int'(hvl_q[3:0]) + 4)
            return ift_pkg::ST_SHORT;
        return ift_pkg::ST_OK;
    endfunction

    function automatic void parse_byte(ift_pkg::t_in_req r);
        int off, rel, pbase, ip_start;
        logic [7:0] b;
        logic [31:0] t32;
        logic [15:0] t16;
        ift_pkg::t_out_req t;
        b = r.frame_byte;
        off = int'(off_q);
        if (off == int'(ift_pkg::OFF_TYPE_HI) || off == int'(ift_pkg::OFF_TYPE_LO))
            outer_q = {outer_q[7:0], b};
        if (off >= int'(ift_pkg::IP_START)) begin
            if (outer_q == ift_pkg::ETYPE_VLAN &&
                (off == int'(ift_pkg::OFF_INNER_HI) || off == int'(ift_pkg::OFF_INNER_LO)))
                inner_q = {inner_q[7:0], b};
            ip_start = (outer_q == ift_pkg::ETYPE_VLAN) ? int'(ift_pkg::IP_START_TAG)
                                                        : int'(ift_pkg::IP_START);
            if (off >= ip_start) begin
                rel = off - ip_start;
                if (rel == 0) hvl_q = b;
                if (rel == 9) proto_q = b;
                if (rel >= 12 && rel <= 15) sa_q = {sa_q[23:0], b};
                if (rel >= 16 && rel <= 19) da_q = {da_q[23:0], b};
                pbase = 4 * int'(hvl_q[3:0]);
                if (rel == pbase || rel == pbase + 1) sp_q = {sp_q[7:0], b};
                if (rel == pbase + 2 || rel == pbase + 3) dp_q = {dp_q[7:0], b};
            end
        end
        if (off_q < ift_pkg::OFFSET_MAX) off_q = off_q + 7'd1;
        if (r.last_byte) begin
            t = '0;
            t.status = frame_status(off + 1, r.interface_index);
            if (t.status == ift_pkg::ST_OK) begin
                t.source_address = sa_q;
                t.dest_address = da_q;
                t.protocol_number = proto_q;
                if (proto_q != ift_pkg::PROTO_ICMP) begin
                    t.source_port = sp_q;
                    t.dest_port = dp_q;
                end
                if (r.is_receive) begin
                    t32 = t.source_address;
                    t.source_address = t.dest_address;
                    t.dest_address = t32;
                    t16 = t.source_port;
                    t.source_port = t.dest_port;
                    t.dest_port = t16;
                end
            end
            tuple_q.push_back(t);
            off_q = '0;
            outer_q = '0;
            inner_q = '0;
            hvl_q = '0;
            proto_q = '0;
            sa_q = '0;
            da_q = '0;
            sp_q = '0;
            dp_q = '0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    function automatic logic [7:0] pad_byte(int fill);
        if (fill == 1) return 8'h00;
        if (fill == 2) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic queue_frame(input bit vlan, input logic [15:0] etype,
                               input logic [3:0] ver, input logic [3:0] ihl,
                               input logic [7:0] proto, input int extra, input int fill,
                               input int cut, input bit rcv, input logic [15:0] ifx);
        logic [7:0] bytes[$];
        int ip_len, first;
        ift_pkg::t_in_req r;
        for (int i = 0; i < 12; i++) bytes.push_back(pad_byte(fill));
        if (vlan) begin
            bytes.push_back(ift_pkg::ETYPE_VLAN[15:8]);
            bytes.push_back(ift_pkg::ETYPE_VLAN[7:0]);
            bytes.push_back(pad_byte(fill));
            bytes.push_back(pad_byte(fill));
        end
        bytes.push_back(etype[15:8]);
        bytes.push_back(etype[7:0]);
        ip_len = ((4 * int'(ihl) + 4 > 20) ? 4 * int'(ihl) + 4 : 20) + extra;
        first = bytes.size();
        for (int i = 0; i < ip_len; i++) bytes.push_back(pad_byte(fill));
        bytes[first] = {ver, ihl};
        bytes[first + 9] = proto;
        if (cut > 0 && cut < bytes.size()) bytes = bytes[0:cut-1];
        for (int i = 0; i < bytes.size(); i++) begin
            r.frame_byte = bytes[i];
            r.last_byte = (i == bytes.size() - 1);
            r.is_receive = r.last_byte ? rcv : 1'($urandom);
            r.interface_index = r.last_byte ? ifx : 16'($urandom);
            frame_reqs.push_back(r);
        end
    endtask

    task automatic wait_drain();
        do begin
            @(posedge clk);
            #1;
        end while (frame_reqs.size() != 0 || in_valid || tuple_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_filter(input logic [15:0] value);
        wait_drain();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        filter_q = value;
        n_settings++;
    endtask

    task automatic random_frame();
        bit vlan, rcv;
        logic [3:0] ihl;
        logic [7:0] proto;
        logic [15:0] ifx;
        int extra, sel;
        rcv = 1'($urandom);
        ifx = (filter_q != 0 && $urandom_range(0, 1) == 0) ? filter_q : 16'($urandom);
        vlan = ($urandom_range(0, 9) < 3);
        ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        case ($urandom_range(0, 2))
            0: proto = ift_pkg::PROTO_TCP;
            1: proto = ift_pkg::PROTO_UDP;
            default: proto = ift_pkg::PROTO_ICMP;
        endcase
        extra = ($urandom_range(0, 49) == 0) ? $urandom_range(90, 130) : $urandom_range(0, 12);
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            queue_frame(vlan, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, ihl, proto, extra,
                        0, 0, rcv, ifx);
        end else if (sel < 65) begin
            queue_frame(vlan, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, ihl, proto, extra,
                        0, $urandom_range(1, 22 + 4 * int'(ihl)), rcv, ifx);
        end else if (sel < 85) begin
            case ($urandom_range(0, 4))
                0: queue_frame(0, 16'($urandom), ift_pkg::IP_VERSION_4, ihl, proto, extra,
                               0, 0, rcv, ifx);
                1: queue_frame(1, 16'($urandom), ift_pkg::IP_VERSION_4, ihl, proto, extra,
                               0, 0, rcv, ifx);
                2: queue_frame(vlan, ift_pkg::ETYPE_IPV4, 4'($urandom), ihl, proto, extra,
                               0, 0, rcv, ifx);
                3: queue_frame(vlan, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, ihl,
                               8'($urandom), extra, 0, 0, rcv, ifx);
                default: queue_frame(vlan, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4,
                                     4'($urandom_range(0, 4)), proto, extra, 0, 0,
                                     rcv, ifx);
            endcase
        end else begin
            queue_frame(1'($urandom), 16'($urandom), 4'($urandom), 4'($urandom), 8'($urandom),
                        $urandom_range(0, 20), 0, $urandom_range(1, 48), rcv, ifx);
        end
    endtask

    // Sender: requests leave the pending queue in bursts, most of them followed by a gap.
    always @(negedge clk) begin : sender
        int burst_left, gap_left;
        logic nv;
        ift_pkg::t_in_req nr;
        nv = in_valid;
        nr = in_req;
        if (!in_valid || in_taken) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (frame_reqs.size() != 0) begin
                nr = frame_reqs.pop_front();
                nv = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 7))
                        0, 1: gap_left = 0;
                        2: gap_left = $urandom_range(10, 25);
                        default: gap_left = $urandom_range(1, 5);
                    endcase
                end
            end
        end
        in_valid <= nv;
        in_req <= nr;
    end

    // Receiver: stalls on its own pattern, with one long hold-off.
    always @(negedge clk) begin : receiver
        int hold_left, mode_left, stall_mode, pat_cnt;
        logic s;
        pat_cnt++;
        if (hold_left > 0) begin
            hold_left--;
            s = 1'b1;
        end else if (!hold_done && n_bytes >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            s = 1'b1;
        end else begin
            if (mode_left <= 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                0: s = 1'b0;
                1: s = ($urandom_range(0, 3) == 0);
                2: s = ($urandom_range(0, 3) != 0);
                default: s = ((pat_cnt % 5) < 2);
            endcase
        end
        out_stall <= s;
    end

    always @(posedge clk) begin : scoreboard
        ift_pkg::t_out_req exp_t;
        if (rst_n && out_valid && !out_stall) begin
            if (tuple_q.size() == 0) begin
                $error("result with no frame pending: %0h", out_req);
                err_cnt++;
            end else begin
                exp_t = tuple_q.pop_front();
                check_field("status", exp_t.status, out_req.status);
                check_field("source_address", exp_t.source_address, out_req.source_address);
                check_field("dest_address", exp_t.dest_address, out_req.dest_address);
                check_field("protocol_number", exp_t.protocol_number,
                            out_req.protocol_number);
                check_field("source_port", exp_t.source_port, out_req.source_port);
                check_field("dest_port", exp_t.dest_port, out_req.dest_port);
                status_cnt[exp_t.status]++;
                n_tuples++;
            end
        end
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken) begin
            n_bytes++;
            parse_byte(in_req);
        end
    end

    always @(posedge clk) begin : watchdog
        int idle_cycles;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (frame_reqs.size() == 0 && !in_valid && tuple_q.size() == 0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ipv4_flow_tuple_extractor: mismatch");
            $finish;
        end
    end

    initial begin
        logic [15:0] filters[5];
        int phase_bytes;
        filters = '{16'h0000, 16'($urandom_range(2, 16'hFFFE)), 16'hFFFF, 16'h0001, 16'h0000};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_filter(16'h0000);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_TCP,
                    0, 1, 0, 0, 16'h0000);
        queue_frame(1, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd15, ift_pkg::PROTO_UDP,
                    4, 2, 0, 1, 16'hFFFF);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_ICMP,
                    8, 0, 0, 1, 16'h1234);
        queue_frame(1, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd7, ift_pkg::PROTO_TCP,
                    82, 0, 0, 0, 16'h0042);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd5, 8'h2F,
                    0, 0, 0, 0, 16'h0001);
        queue_frame(0, 16'h86DD, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_TCP,
                    0, 0, 0, 1, 16'h0002);
        queue_frame(1, 16'h86DD, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_UDP,
                    0, 0, 0, 0, 16'h0003);
        queue_frame(0, ift_pkg::ETYPE_IPV4, 4'd6, 4'd5, ift_pkg::PROTO_TCP,
                    0, 0, 0, 1, 16'h0004);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd0, ift_pkg::PROTO_TCP,
                    2, 0, 0, 1, 16'h0005);
        queue_frame(1, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd3, ift_pkg::PROTO_UDP,
                    0, 0, 0, 0, 16'h0006);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_TCP,
                    0, 0, 1, 0, 16'h0007);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_TCP,
                    0, 0, 13, 0, 16'h0008);
        queue_frame(1, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_UDP,
                    0, 0, 17, 1, 16'h0009);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_TCP,
                    0, 0, 14, 0, 16'h000A);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_UDP,
                    0, 0, 23, 1, 16'h000B);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_TCP,
                    0, 0, 33, 0, 16'h000C);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd8, ift_pkg::PROTO_TCP,
                    0, 0, 49, 1, 16'h000D);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd8, ift_pkg::PROTO_ICMP,
                    0, 0, 34, 0, 16'h000E);

        set_filter(16'hFFFF);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_TCP,
                    3, 0, 0, 1, 16'hFFFF);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_UDP,
                    0, 0, 0, 0, 16'h0000);
        queue_frame(0, ift_pkg::ETYPE_IPV4, ift_pkg::IP_VERSION_4, 4'd5, ift_pkg::PROTO_TCP,
                    0, 0, 5, 1, 16'h7FFF);

        foreach (filters[p]) begin
            set_filter(filters[p]);
            phase_bytes = frame_reqs.size();
            for (int k = 0; k < 1 || phase_bytes < 24; k++) begin
                random_frame();
                phase_bytes = frame_reqs.size();
            end
        end

        wait_drain();
        repeat (8) @(posedge clk);
        $display("Checked %0d tuples from %0d frame bytes over %0d filter settings.",
                 n_tuples, n_bytes, n_settings);
        $display("Status counts ok/filtered/unsupported/short: %0d/%0d/%0d/%0d",
                 status_cnt[ift_pkg::ST_OK], status_cnt[ift_pkg::ST_FILTERED],
                 status_cnt[ift_pkg::ST_UNSUPPORTED], status_cnt[ift_pkg::ST_SHORT]);
        if (err_cnt == 0 && tuple_q.size() == 0) begin
            $display("ipv4_flow_tuple_extractor: match");
        end else begin
            $display("ipv4_flow_tuple_extractor: mismatch");
        end
        $finish;
    end

endmodule
